FILE: sv/twntt_pkg.sv
package twntt_pkg;

    // store sizes and radix limit
    localparam int MAX_RADIX     = 16;
    localparam int COEF_DEPTH    = 1024;
    localparam int TWIDDLE_DEPTH = 1024;
    localparam int COEF_AW       = $clog2(COEF_DEPTH);
    localparam int TWIDDLE_AW    = $clog2(TWIDDLE_DEPTH);

    // input operation codes
    localparam logic [1:0] OP_LOAD_COEF    = 2'd0;
    localparam logic [1:0] OP_LOAD_TWIDDLE = 2'd1;
    localparam logic [1:0] OP_COMPUTE      = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MODULUS       = 3'd0;
    localparam logic [2:0] REG_RADIX         = 3'd1;
    localparam logic [2:0] REG_COLUMN_COUNT  = 3'd2;
    localparam logic [2:0] REG_TWIST         = 3'd3;
    localparam logic [2:0] REG_ROOT_ORDER    = 3'd4;
    localparam logic [2:0] REG_INVERSE_MODE  = 3'd5;
    localparam logic [2:0] REG_RADIX_INVERSE = 3'd6;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV0,
        ST_SETUP1,
        ST_DIV1,
        ST_SETUP2,
        ST_TERM,
        ST_MUL,
        ST_MOD,
        ST_ACC,
        ST_FIN,
        ST_FMOD,
        ST_DONE
    } state_t;

endpackage

FILE: sv/twisted_ntt_split_map.sv
// Radix-k twisted NTT split map, one output coefficient per compute request.
// Input channel (in_valid/in_ready) carries op, slot, value, row and col.
// A load op writes value into the coefficient store or twiddle table at slot
// and yields no result. A compute op yields one result on the output channel
// (out_valid/out_ready): out_row, out_col, result_value and index_error.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. For radix k, one shared bit-serial
// divide/remainder unit does two divisions by k, then one reduction mod p
// per term, each term preceded by a store read and a multiply; inverse mode
// adds a final reduction mod p. An index error ends the request at once.
// Loads leave the block idle and ready for the next request.
// The finished result sits in an output register; loads and a new compute
// are taken while it waits, and a second compute stalls at its end until
// the receiver takes the first result.
// Reset (rst_n low, asynchronous) restores the register defaults and clears
// the pending output; store contents are undefined until written.
module twisted_ntt_split_map
    import twntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [9:0]            slot,
    input  logic [15:0]           value,
    input  logic [3:0]            row,
    input  logic [9:0]            col,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            out_row,
    output logic [9:0]            out_col,
    output logic [15:0]           result_value,
    output logic                  index_error
);

    // configuration registers
    logic [15:0] modulus_reg;
    logic [4:0]  radix_reg;
    logic [10:0] column_count_reg;
    logic [9:0]  twist_reg;
    logic [10:0] root_order_reg;
    logic        inverse_mode_reg;
    logic [15:0] radix_inverse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg       <= 16'd2;
            radix_reg         <= 5'd1;
            column_count_reg  <= 11'd1;
            twist_reg         <= 10'd0;
            root_order_reg    <= 11'd1;
            inverse_mode_reg  <= 1'b0;
            radix_inverse_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODULUS:       modulus_reg       <= cfg_data;
                REG_RADIX:         radix_reg         <= cfg_data[4:0];
                REG_COLUMN_COUNT:  column_count_reg  <= cfg_data[10:0];
                REG_TWIST:         twist_reg         <= cfg_data[9:0];
                REG_ROOT_ORDER:    root_order_reg    <= cfg_data[10:0];
                REG_INVERSE_MODE:  inverse_mode_reg  <= cfg_data[0];
                REG_RADIX_INVERSE: radix_inverse_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    logic [15:0] p_eff;
    assign p_eff = (modulus_reg == 16'd0) ? 16'd1 : modulus_reg;

    // sequencer and datapath registers
    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [3:0]  row_reg, row_next;
    logic [9:0]  col_reg, col_next;
    logic        err_reg, err_next;
    logic [15:0] q0_reg, q0_next;
    logic [15:0] qn_reg, qn_next;
    logic [4:0]  rn_reg, rn_next;
    logic [4:0]  er_reg, er_next;
    logic [15:0] e_reg, e_next;
    logic [3:0]  t_reg, t_next;
    logic [15:0] cidx_reg, cidx_next;
    logic [19:0] tacc_reg, tacc_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] res_reg, res_next;

    logic        out_valid_reg;
    logic [3:0]  out_row_reg;
    logic [9:0]  out_col_reg;
    logic [15:0] out_value_reg;
    logic        out_err_reg;

    // memories
    logic [15:0] coef_mem [COEF_DEPTH];
    logic [15:0] tw_mem [TWIDDLE_DEPTH];
    logic [15:0] coef_rdata_reg;
    logic [15:0] tw_rdata_reg;
    logic [COEF_AW-1:0]    coef_raddr;
    logic [TWIDDLE_AW-1:0] tw_raddr;

    logic in_xfer;
    logic out_load;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (in_xfer && op == OP_LOAD_COEF)
        begin
            coef_mem[slot[COEF_AW-1:0]] <= value;
        end
        coef_rdata_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && op == OP_LOAD_TWIDDLE)
        begin
            tw_mem[slot[TWIDDLE_AW-1:0]] <= value;
        end
        tw_rdata_reg <= tw_mem[tw_raddr];
    end

    // shared restoring divide/remainder step
    logic [16:0] trial;
    logic        trial_ge;
    logic [15:0] rem_step;
    assign trial    = {rem_reg, num_reg[31]};
    assign trial_ge = trial >= {1'b0, dsr_reg};
    assign rem_step = trial_ge ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];

    // request checks
    logic basic_err;
    assign basic_err = (radix_reg == 5'd0) || (radix_reg > 5'(MAX_RADIX))
                    || ({1'b0, row} >= radix_reg) || ({1'b0, col} >= column_count_reg);

    // twiddle index of the current term
    logic [19:0] inv_prod;
    logic        inv_neg;
    logic [19:0] inv_ti;
    logic        term_bad;
    logic        last_term;
    assign inv_prod  = 20'(e_reg) * 20'(row_reg);
    assign inv_neg   = inv_prod > 20'(root_order_reg);
    assign inv_ti    = 20'(root_order_reg) - inv_prod;
    assign term_bad  = (cidx_reg >= 16'(COEF_DEPTH))
                    || (inverse_mode_reg ? (inv_neg || inv_ti >= 20'(TWIDDLE_DEPTH))
                                         : (tacc_reg >= 20'(TWIDDLE_DEPTH)));
    assign last_term = ({1'b0, t_reg} == 5'(radix_reg - 5'd1));
    assign coef_raddr = cidx_reg[COEF_AW-1:0];
    assign tw_raddr   = inverse_mode_reg ? inv_ti[TWIDDLE_AW-1:0]
                                         : tacc_reg[TWIDDLE_AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && op == OP_COMPUTE)
                begin
                    state_next = basic_err ? ST_DONE : ST_DIV0;
                end
            end
            ST_DIV0:   state_next = (cnt_reg == 5'd31) ? ST_SETUP1 : ST_DIV0;
            ST_SETUP1: state_next = ST_DIV1;
            ST_DIV1:   state_next = (cnt_reg == 5'd31) ? ST_SETUP2 : ST_DIV1;
            ST_SETUP2: state_next = ST_TERM;
            ST_TERM:   state_next = term_bad ? ST_DONE : ST_MUL;
            ST_MUL:    state_next = ST_MOD;
            ST_MOD:    state_next = (cnt_reg == 5'd31) ? ST_ACC : ST_MOD;
            ST_ACC:    state_next = last_term ? ST_FIN : ST_TERM;
            ST_FIN:    state_next = inverse_mode_reg ? ST_FMOD : ST_DONE;
            ST_FMOD:   state_next = (cnt_reg == 5'd31) ? ST_DONE : ST_FMOD;
            ST_DONE:   state_next = out_load ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    logic [16:0] acc_sum;
    logic [5:0]  er_sum;
    logic        er_wrap;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, rem_reg};
    assign er_sum  = {1'b0, er_reg} + {1'b0, rn_reg};
    assign er_wrap = er_sum >= {1'b0, radix_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        err_next  = err_reg;
        q0_next   = q0_reg;
        qn_next   = qn_reg;
        rn_next   = rn_reg;
        er_next   = er_reg;
        e_next    = e_reg;
        t_next    = t_reg;
        cidx_next = cidx_reg;
        tacc_next = tacc_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next = row;
                col_next = col;
                err_next = basic_err;
                res_next = 16'd0;
                cnt_next = 5'd0;
                rem_next = 16'd0;
                dsr_next = {11'd0, radix_reg};
                num_next = inverse_mode_reg ? 32'(twist_reg)
                                            : 32'(twist_reg) + 32'(row) * 32'(root_order_reg);
            end
            ST_DIV0, ST_DIV1, ST_MOD, ST_FMOD:
            begin
                cnt_next = cnt_reg + 5'd1;
                rem_next = rem_step;
                num_next = {num_reg[30:0], trial_ge};
            end
            ST_SETUP1:
            begin
                q0_next  = num_reg[15:0];
                er_next  = rem_reg[4:0];
                cnt_next = 5'd0;
                rem_next = 16'd0;
                num_next = 32'(root_order_reg);
            end
            ST_SETUP2:
            begin
                qn_next   = num_reg[15:0];
                rn_next   = rem_reg[4:0];
                e_next    = q0_reg;
                t_next    = 4'd0;
                cidx_next = {6'd0, col_reg};
                tacc_next = 20'd0;
                acc_next  = 16'd0;
            end
            ST_TERM:
            begin
                if (term_bad)
                begin
                    err_next = 1'b1;
                    res_next = 16'd0;
                end
            end
            ST_MUL:
            begin
                num_next = 32'(coef_rdata_reg) * 32'(tw_rdata_reg);
                rem_next = 16'd0;
                dsr_next = p_eff;
                cnt_next = 5'd0;
            end
            ST_ACC:
            begin
                acc_next  = (acc_sum >= {1'b0, p_eff}) ? 16'(acc_sum - {1'b0, p_eff})
                                                       : acc_sum[15:0];
                t_next    = t_reg + 4'd1;
                cidx_next = cidx_reg + {5'd0, column_count_reg};
                tacc_next = tacc_reg + {4'd0, q0_reg};
                er_next   = er_wrap ? 5'(er_sum - {1'b0, radix_reg}) : er_sum[4:0];
                e_next    = e_reg + qn_reg + {15'd0, er_wrap};
            end
            ST_FIN:
            begin
                res_next = acc_reg;
                num_next = 32'(acc_reg) * 32'(radix_inverse_reg);
                rem_next = 16'd0;
                cnt_next = 5'd0;
            end
            ST_DONE:   ;
            default:   ;
        endcase
        if (state_reg == ST_FMOD && cnt_reg == 5'd31)
        begin
            res_next = rem_step;
        end
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        err_reg  <= err_next;
        q0_reg   <= q0_next;
        qn_reg   <= qn_next;
        rn_reg   <= rn_next;
        er_reg   <= er_next;
        e_reg    <= e_next;
        t_reg    <= t_next;
        cidx_reg <= cidx_next;
        tacc_reg <= tacc_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    // output register, held until the receiver takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_value_reg <= err_reg ? 16'd0 : res_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign result_value = out_value_reg;
    assign index_error  = out_err_reg;

endmodule
